[src/i2c_master_register_access_defines.svh]
// Assertion macros for the RTL of the I2C master, included by i2cm_seq.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk, skipped while rst is high.
`define I2CM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define I2CM_ASSERT(lbl, clk, rst, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/i2cm_pkg.sv]
package i2cm_pkg;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0] MSB_MASK          = 8'h80;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_S3,
    PH_S4,
    PH_RS1,
    PH_RS2,
    PH_RS3,
    PH_RS4,
    PH_TX_LO,
    PH_TX_HI,
    PH_TX_ACK_LO,
    PH_TX_ACK_HI,
    PH_TX_POLL,
    PH_RD_LO,
    PH_RD_HI,
    PH_MACK_LO,
    PH_MACK_HI,
    PH_STOP1,
    PH_STOP2,
    PH_STOP3,
    PH_ESTOP2,
    PH_ESTOP3
  } phase_t;

  // Which byte a transmit phase is sending.
  typedef enum logic [1:0] {
    CTX_AW,
    CTX_MID,
    CTX_AR
  } ctx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wdata;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       wdata_taken;
    logic       done_res;
    logic       error;
    logic       busy_res;
  } rsp_t;

endpackage

[src/i2cm_in_stage.sv]
module i2cm_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  i2cm_pkg::req_t req,
  output logic          item_valid,
  output i2cm_pkg::req_t item,
  input  logic          advance
);

  logic           valid_q;
  i2cm_pkg::req_t item_q;

  // A held beat leaves in the same cycle that a new one may enter.
  assign req_ready  = !valid_q || advance;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (req_ready) begin
      valid_q <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item_q <= req;
    end
  end

endmodule

[src/i2cm_seq.sv]
`include "i2c_master_register_access_defines.svh"

module i2cm_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_data,
  input  logic           fire,
  input  i2cm_pkg::req_t item,
  output i2cm_pkg::rsp_t result
);

  i2cm_pkg::phase_t phase, phase_next;
  i2cm_pkg::ctx_t   ctx, ctx_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] ack_wait_count, ack_wait_count_next;
  logic       is_read, is_read_next;
  logic [6:0] slave_address, slave_address_next;
  logic [7:0] register_address, register_address_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       sda_driven, sda_driven_next;
  logic [7:0] ack_timeout;

  logic [3:0] bit_inc;
  logic [7:0] shift_in;
  logic       is_start;
  logic       ack_seen;
  logic       ack_expired;
  logic [7:0] rdata;
  logic       rvalid;
  logic       taken;
  logic       done;
  logic       err;

  assign bit_inc     = bit_index + 4'd1;
  assign shift_in    = {shift_byte[6:0], item.sda_in};
  assign is_start    = (item.cmd == i2cm_pkg::CMD_WRITE) || (item.cmd == i2cm_pkg::CMD_READ);
  assign ack_seen    = !item.sda_in;
  assign ack_expired = ack_wait_count >= ack_timeout;

  // Next phase and byte context.
  always_comb begin
    phase_next = phase;
    ctx_next   = ctx;
    case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (is_start) phase_next = i2cm_pkg::PH_S3;
      end
      i2cm_pkg::PH_S3:  phase_next = i2cm_pkg::PH_S4;
      i2cm_pkg::PH_S4: begin
        phase_next = i2cm_pkg::PH_TX_LO;
        ctx_next   = i2cm_pkg::CTX_AW;
      end
      i2cm_pkg::PH_RS1: phase_next = i2cm_pkg::PH_RS2;
      i2cm_pkg::PH_RS2: phase_next = i2cm_pkg::PH_RS3;
      i2cm_pkg::PH_RS3: phase_next = i2cm_pkg::PH_RS4;
      i2cm_pkg::PH_RS4: begin
        phase_next = i2cm_pkg::PH_TX_LO;
        ctx_next   = i2cm_pkg::CTX_AR;
      end
      i2cm_pkg::PH_TX_LO: phase_next = i2cm_pkg::PH_TX_HI;
      i2cm_pkg::PH_TX_HI: begin
        phase_next = bit_inc[3] ? i2cm_pkg::PH_TX_ACK_LO : i2cm_pkg::PH_TX_LO;
      end
      i2cm_pkg::PH_TX_ACK_LO: phase_next = i2cm_pkg::PH_TX_ACK_HI;
      i2cm_pkg::PH_TX_ACK_HI: phase_next = i2cm_pkg::PH_TX_POLL;
      i2cm_pkg::PH_TX_POLL: begin
        if (ack_seen) begin
          if (ctx == i2cm_pkg::CTX_AW) begin
            phase_next = i2cm_pkg::PH_TX_LO;
            ctx_next   = i2cm_pkg::CTX_MID;
          end else if (ctx == i2cm_pkg::CTX_MID && is_read) begin
            phase_next = i2cm_pkg::PH_RS1;
          end else if (bytes_left == 8'd0) begin
            phase_next = i2cm_pkg::PH_STOP1;
          end else if (ctx == i2cm_pkg::CTX_MID) begin
            phase_next = i2cm_pkg::PH_TX_LO;
          end else begin
            phase_next = i2cm_pkg::PH_RD_LO;
          end
        end else if (ack_expired) begin
          phase_next = i2cm_pkg::PH_ESTOP2;
        end
      end
      i2cm_pkg::PH_RD_LO: phase_next = i2cm_pkg::PH_RD_HI;
      i2cm_pkg::PH_RD_HI: begin
        phase_next = bit_inc[3] ? i2cm_pkg::PH_MACK_LO : i2cm_pkg::PH_RD_LO;
      end
      i2cm_pkg::PH_MACK_LO: phase_next = i2cm_pkg::PH_MACK_HI;
      i2cm_pkg::PH_MACK_HI: begin
        phase_next = (bytes_left == 8'd0) ? i2cm_pkg::PH_STOP1 : i2cm_pkg::PH_RD_LO;
      end
      i2cm_pkg::PH_STOP1:  phase_next = i2cm_pkg::PH_STOP2;
      i2cm_pkg::PH_STOP2:  phase_next = i2cm_pkg::PH_STOP3;
      i2cm_pkg::PH_STOP3:  phase_next = i2cm_pkg::PH_IDLE;
      i2cm_pkg::PH_ESTOP2: phase_next = i2cm_pkg::PH_ESTOP3;
      i2cm_pkg::PH_ESTOP3: phase_next = i2cm_pkg::PH_IDLE;
      default:             phase_next = i2cm_pkg::PH_IDLE;
    endcase
  end

  // Bus levels, shifter, counters and result flags.
  always_comb begin
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    ack_wait_count_next   = ack_wait_count;
    is_read_next          = is_read;
    slave_address_next    = slave_address;
    register_address_next = register_address;
    scl_level_next        = scl_level;
    sda_level_next        = sda_level;
    sda_driven_next       = sda_driven;
    rdata                 = 8'd0;
    rvalid                = 1'b0;
    taken                 = 1'b0;
    done                  = 1'b0;
    err                   = 1'b0;
    case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (is_start) begin
          slave_address_next    = item.dev_addr;
          register_address_next = item.reg_addr;
          bytes_left_next       = item.byte_count;
          is_read_next          = (item.cmd == i2cm_pkg::CMD_READ);
          scl_level_next        = 1'b1;
          sda_level_next        = 1'b1;
          sda_driven_next       = 1'b1;
        end
      end
      i2cm_pkg::PH_S3: begin
        sda_driven_next = 1'b1;
        sda_level_next  = 1'b0;
      end
      i2cm_pkg::PH_S4: begin
        scl_level_next  = 1'b0;
        shift_byte_next = {slave_address, 1'b0};
        bit_index_next  = 4'd0;
      end
      i2cm_pkg::PH_RS1: begin
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b1;
        sda_level_next  = 1'b1;
      end
      i2cm_pkg::PH_RS2: scl_level_next = 1'b1;
      i2cm_pkg::PH_RS3: begin
        sda_driven_next = 1'b1;
        sda_level_next  = 1'b0;
      end
      i2cm_pkg::PH_RS4: begin
        scl_level_next  = 1'b0;
        shift_byte_next = {slave_address, 1'b1};
        bit_index_next  = 4'd0;
      end
      i2cm_pkg::PH_TX_LO: begin
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b1;
        sda_level_next  = (shift_byte & i2cm_pkg::MSB_MASK) != 8'd0;
        shift_byte_next = {shift_byte[6:0], 1'b0};
      end
      i2cm_pkg::PH_TX_HI: begin
        scl_level_next = 1'b1;
        bit_index_next = bit_inc;
      end
      i2cm_pkg::PH_TX_ACK_LO: begin
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b0;
        sda_level_next  = 1'b1;
      end
      i2cm_pkg::PH_TX_ACK_HI: begin
        scl_level_next      = 1'b1;
        ack_wait_count_next = 8'd0;
      end
      i2cm_pkg::PH_TX_POLL: begin
        if (ack_seen) begin
          scl_level_next = 1'b0;
          if (ctx == i2cm_pkg::CTX_AW) begin
            shift_byte_next = register_address;
            bit_index_next  = 4'd0;
          end else if (ctx == i2cm_pkg::CTX_MID && is_read) begin
            // Repeated start follows; nothing to load.
          end else if (bytes_left == 8'd0) begin
            // Last byte acknowledged; go to stop.
          end else if (ctx == i2cm_pkg::CTX_MID) begin
            shift_byte_next = item.wdata;
            bit_index_next  = 4'd0;
            taken           = 1'b1;
            bytes_left_next = bytes_left - 8'd1;
          end else begin
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
          end
        end else if (ack_expired) begin
          scl_level_next  = 1'b0;
          sda_driven_next = 1'b1;
          sda_level_next  = 1'b0;
        end else begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end
      end
      i2cm_pkg::PH_RD_LO: begin
        if (bit_index != 4'd0) shift_byte_next = shift_in;
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b0;
        sda_level_next  = 1'b1;
      end
      i2cm_pkg::PH_RD_HI: begin
        scl_level_next = 1'b1;
        bit_index_next = bit_inc;
      end
      i2cm_pkg::PH_MACK_LO: begin
        shift_byte_next = shift_in;
        rdata           = shift_in;
        rvalid          = 1'b1;
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b1;
        // The last byte of the burst is answered with a NACK.
        sda_level_next  = bytes_left <= 8'd1;
        if (bytes_left != 8'd0) bytes_left_next = bytes_left - 8'd1;
      end
      i2cm_pkg::PH_MACK_HI: begin
        scl_level_next = 1'b1;
        if (bytes_left != 8'd0) begin
          shift_byte_next = 8'd0;
          bit_index_next  = 4'd0;
        end
      end
      i2cm_pkg::PH_STOP1: begin
        scl_level_next  = 1'b0;
        sda_driven_next = 1'b1;
        sda_level_next  = 1'b0;
      end
      i2cm_pkg::PH_STOP2, i2cm_pkg::PH_ESTOP2: scl_level_next = 1'b1;
      i2cm_pkg::PH_STOP3, i2cm_pkg::PH_ESTOP3: begin
        sda_driven_next = 1'b0;
        sda_level_next  = 1'b1;
        done            = 1'b1;
        err             = (phase == i2cm_pkg::PH_ESTOP3);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.scl         = scl_level_next;
    result.sda_out     = sda_driven_next ? sda_level_next : 1'b1;
    result.sda_drive   = sda_driven_next;
    result.rdata       = rdata;
    result.rdata_valid = rvalid;
    result.wdata_taken = taken;
    result.done_res    = done;
    result.error       = err;
    result.busy_res    = phase_next != i2cm_pkg::PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      ack_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2cm_pkg::PH_IDLE;
      ctx              <= i2cm_pkg::CTX_AW;
      bit_index        <= 4'd0;
      shift_byte       <= 8'd0;
      bytes_left       <= 8'd0;
      ack_wait_count   <= 8'd0;
      is_read          <= 1'b0;
      slave_address    <= 7'd0;
      register_address <= 8'd0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
      sda_driven       <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      ctx              <= ctx_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      bytes_left       <= bytes_left_next;
      ack_wait_count   <= ack_wait_count_next;
      is_read          <= is_read_next;
      slave_address    <= slave_address_next;
      register_address <= register_address_next;
      scl_level        <= scl_level_next;
      sda_level        <= sda_level_next;
      sda_driven       <= sda_driven_next;
    end
  end

  `I2CM_ASSERT(a_rvalid_then_mack_hi, clk, rst,
    fire && rvalid |=> phase == i2cm_pkg::PH_MACK_HI,
    "read byte not followed by master ack high phase")
  `I2CM_ASSERT(a_done_then_idle, clk, rst,
    fire && done |=> phase == i2cm_pkg::PH_IDLE,
    "transaction end did not return to idle")
  `I2CM_ASSERT(a_taken_loads_shifter, clk, rst,
    fire && taken |=> phase == i2cm_pkg::PH_TX_LO && ctx == i2cm_pkg::CTX_MID
      && shift_byte == $past(item.wdata),
    "taken write byte not loaded")
  `I2CM_ASSERT(a_bit_index_range, clk, rst, bit_index <= 4'd8, "bit counter ran past eight")

endmodule

[src/i2cm_out_stage.sv]
module i2cm_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::rsp_t result,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output i2cm_pkg::rsp_t rsp
);

  logic           valid_q;
  i2cm_pkg::rsp_t rsp_q;

  assign rsp_valid = valid_q;
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (rsp_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_q <= result;
    end
  end

endmodule

[src/i2c_master_register_access.sv]
// Channel  Dir  Handshake              Beat
// req      in   req_valid/req_ready    one command or tick (i2cm_pkg::req_t)
// rsp      out  rsp_valid/rsp_ready    one bus step result (i2cm_pkg::rsp_t)
// cfg      in   cfg_valid/cfg_ready    ack_timeout value, 8 bits
//
// Every req beat yields exactly one rsp beat: it is held in the input register,
// stepped through the sequencer and registered in the output register. While rsp
// is ready, one beat enters per cycle, so the sustained rate is one beat per cycle.
// Reset is synchronous: the bus idles with SCL high and SDA released, and
// ack_timeout returns to 250. A stalled rsp side holds the result register,
// and the req side stalls only when both registers are full and rsp is stalled.
// cfg_ready is always high; writes take effect on the next cycle.

module i2c_master_register_access (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  i2cm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output i2cm_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);

  logic           item_valid;
  i2cm_pkg::req_t item;
  i2cm_pkg::rsp_t result;
  logic           advance;

  // The held beat is stepped through the sequencer when the result register
  // is free or is being emptied in this cycle.
  assign advance   = item_valid && (!rsp_valid || rsp_ready);
  assign cfg_ready = 1'b1;

  i2cm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  i2cm_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
